[design/static_linked_list_engine_defines.svh]
// Assertion macros for the list engine RTL.
`ifndef STATIC_LINKED_LIST_ENGINE_DEFINES_SVH
`define STATIC_LINKED_LIST_ENGINE_DEFINES_SVH

// Clocked check, muted while reset is asserted.
`define SLL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also runs during reset.
`define SLL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[design/sll_pkg.sv]
package sll_pkg;

  // Slot array geometry.
  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_MAX    = SLOT_COUNT - 2;

  // Item field widths.
  localparam int unsigned CMD_W  = 1;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 10;

  // Width that holds both a position and a length plus one.
  localparam int unsigned CMP_W = ((SLOT_W > POS_W) ? SLOT_W : POS_W) + 1;

  localparam logic [SLOT_W-1:0] FREE_SLOT = '0;
  localparam logic [SLOT_W-1:0] HEAD_SLOT = SLOT_W'(SLOT_COUNT - 1);

  // Operation codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  typedef enum logic [1:0] {
    RA_FREE,
    RA_HEAD,
    RA_NEXT
  } raddr_sel_e;

  typedef enum logic [1:0] {
    WA_FREE,
    WA_J,
    WA_K,
    WA_INIT
  } waddr_sel_e;

  typedef enum logic [1:0] {
    WD_NEXT,
    WD_J,
    WD_INIT
  } wdata_sel_e;

  // Controller to datapath.
  typedef struct packed {
    logic              init_step;
    logic              capture;
    logic              status_ld;
    logic [STAT_W-1:0] status;
    raddr_sel_e        raddr_sel;
    logic              link_we;
    waddr_sel_e        waddr_sel;
    wdata_sel_e        wdata_sel;
    logic              val_we;
    logic              walk_start;
    logic              walk_step;
    logic              j_ld;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              out_ld;
  } sll_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_delete;
    logic pos_bad;
    logic nx_zero;
    logic nx_head;
    logic walk_more;
    logic init_last;
    logic out_free;
  } sll_stat_t;

  // A link outside the array reads as the free-list head.
  function automatic logic [SLOT_W-1:0] sll_safe(logic [SLOT_W-1:0] s);
    logic in_range;
    in_range = ({1'b0, s} < (SLOT_W+1)'(SLOT_COUNT));
    return in_range ? s : FREE_SLOT;
  endfunction

endpackage

[design/sll_in_if.sv]
interface sll_in_if;
  import sll_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

[design/sll_out_if.sv]
interface sll_out_if;
  import sll_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [LEN_W-1:0]  length;

  modport source (output valid, output status, output length, input ready);
  modport sink   (input valid, input status, input length, output ready);
endinterface

[design/sll_ram.sv]
module sll_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/sll_ctrl.sv]
module sll_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sll_pkg::sll_stat_t stat_i,
  output sll_pkg::sll_ctl_t  ctl_o
);
  import sll_pkg::*;

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_CHECK  = 4'd2;
  localparam logic [3:0] ST_I_FREE = 4'd3;
  localparam logic [3:0] ST_I_POP  = 4'd4;
  localparam logic [3:0] ST_WALK   = 4'd5;
  localparam logic [3:0] ST_I_LINK = 4'd6;
  localparam logic [3:0] ST_D_UNL  = 4'd7;
  localparam logic [3:0] ST_D_FREE = 4'd8;
  localparam logic [3:0] ST_D_PUSH = 4'd9;
  localparam logic [3:0] ST_RESP   = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_INIT: begin
        ctl_o.init_step = 1'b1;
        ctl_o.link_we   = 1'b1;
        ctl_o.waddr_sel = WA_INIT;
        ctl_o.wdata_sel = WD_INIT;
        if (stat_i.init_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.pos_bad) begin
          ctl_o.status_ld = 1'b1;
          ctl_o.status    = STAT_BAD_POS;
          state_d         = ST_RESP;
        end else if (stat_i.is_delete) begin
          ctl_o.walk_start = 1'b1;
          ctl_o.raddr_sel  = RA_HEAD;
          state_d          = ST_WALK;
        end else begin
          ctl_o.raddr_sel = RA_FREE;
          state_d         = ST_I_FREE;
        end
      end
      ST_I_FREE: begin
        if (stat_i.nx_zero) begin
          ctl_o.status_ld = 1'b1;
          ctl_o.status    = STAT_FULL;
          state_d         = ST_RESP;
        end else begin
          ctl_o.j_ld      = 1'b1;
          ctl_o.raddr_sel = RA_NEXT;
          state_d         = ST_I_POP;
        end
      end
      ST_I_POP: begin
        ctl_o.link_we    = 1'b1;
        ctl_o.waddr_sel  = WA_FREE;
        ctl_o.wdata_sel  = WD_NEXT;
        ctl_o.val_we     = 1'b1;
        ctl_o.walk_start = 1'b1;
        ctl_o.raddr_sel  = RA_HEAD;
        state_d          = ST_WALK;
      end
      ST_WALK: begin
        if (stat_i.walk_more) begin
          ctl_o.walk_step = 1'b1;
          ctl_o.raddr_sel = RA_NEXT;
        end else if (!stat_i.is_delete) begin
          ctl_o.link_we   = 1'b1;
          ctl_o.waddr_sel = WA_J;
          ctl_o.wdata_sel = WD_NEXT;
          state_d         = ST_I_LINK;
        end else if (stat_i.nx_zero || stat_i.nx_head) begin
          ctl_o.status_ld = 1'b1;
          ctl_o.status    = STAT_BAD_POS;
          state_d         = ST_RESP;
        end else begin
          ctl_o.j_ld      = 1'b1;
          ctl_o.raddr_sel = RA_NEXT;
          state_d         = ST_D_UNL;
        end
      end
      ST_I_LINK: begin
        ctl_o.link_we   = 1'b1;
        ctl_o.waddr_sel = WA_K;
        ctl_o.wdata_sel = WD_J;
        ctl_o.cnt_inc   = 1'b1;
        ctl_o.status_ld = 1'b1;
        ctl_o.status    = STAT_DONE;
        state_d         = ST_RESP;
      end
      ST_D_UNL: begin
        ctl_o.link_we   = 1'b1;
        ctl_o.waddr_sel = WA_K;
        ctl_o.wdata_sel = WD_NEXT;
        ctl_o.raddr_sel = RA_FREE;
        state_d         = ST_D_FREE;
      end
      ST_D_FREE: begin
        ctl_o.link_we   = 1'b1;
        ctl_o.waddr_sel = WA_J;
        ctl_o.wdata_sel = WD_NEXT;
        state_d         = ST_D_PUSH;
      end
      ST_D_PUSH: begin
        ctl_o.link_we   = 1'b1;
        ctl_o.waddr_sel = WA_FREE;
        ctl_o.wdata_sel = WD_J;
        ctl_o.cnt_dec   = 1'b1;
        ctl_o.status_ld = 1'b1;
        ctl_o.status    = STAT_DONE;
        state_d         = ST_RESP;
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          ctl_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[design/sll_dpath.sv]
`include "static_linked_list_engine_defines.svh"

module sll_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sll_pkg::sll_ctl_t               ctl_i,
  output sll_pkg::sll_stat_t              stat_o,
  input  logic [sll_pkg::CMD_W-1:0]       in_cmd_i,
  input  logic [sll_pkg::POS_W-1:0]       in_position_i,
  input  logic signed [sll_pkg::VAL_W-1:0] in_value_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [sll_pkg::STAT_W-1:0]      out_status_o,
  output logic [sll_pkg::LEN_W-1:0]       out_length_o
);
  import sll_pkg::*;

  // Captured item.
  logic [CMD_W-1:0]        cmd_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [VAL_W-1:0] val_q;

  // Walk and splice registers.
  logic [SLOT_W-1:0] j_q;
  logic [SLOT_W-1:0] k_q;
  logic [POS_W-1:0]  n_q;
  logic [SLOT_W-1:0] cnt_q;
  logic [SLOT_W-1:0] init_q;
  logic [STAT_W-1:0] status_q;

  // Output register.
  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [LEN_W-1:0]  out_len_q;

  // Link memory ports.
  logic [SLOT_W-1:0] link_rdata;
  logic [SLOT_W-1:0] link_raddr;
  logic [SLOT_W-1:0] link_waddr;
  logic [SLOT_W-1:0] link_wdata;
  logic [SLOT_W-1:0] nx;
  logic [SLOT_W-1:0] init_link;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  limit;

  assign nx = sll_safe(link_rdata);

  // Reset image: slot s points to s+1, the last free slot and the head end the chains.
  assign init_link = ({1'b0, init_q} < (SLOT_W+1)'(SLOT_COUNT - 2)) ?
                     SLOT_W'(init_q + 1'b1) : FREE_SLOT;

  always_comb begin
    case (ctl_i.raddr_sel)
      RA_FREE: link_raddr = FREE_SLOT;
      RA_HEAD: link_raddr = HEAD_SLOT;
      RA_NEXT: link_raddr = nx;
      default: link_raddr = FREE_SLOT;
    endcase
  end

  always_comb begin
    case (ctl_i.waddr_sel)
      WA_FREE: link_waddr = FREE_SLOT;
      WA_J:    link_waddr = j_q;
      WA_K:    link_waddr = k_q;
      WA_INIT: link_waddr = init_q;
      default: link_waddr = FREE_SLOT;
    endcase
  end

  always_comb begin
    case (ctl_i.wdata_sel)
      WD_NEXT: link_wdata = nx;
      WD_J:    link_wdata = j_q;
      WD_INIT: link_wdata = init_link;
      default: link_wdata = FREE_SLOT;
    endcase
  end

  sll_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  // Element values are stored but never reported.
  sll_ram #(
    .WIDTH (VAL_W),
    .DEPTH (SLOT_COUNT)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.val_we),
    .waddr_i (j_q),
    .wdata_i (val_q),
    .raddr_i (FREE_SLOT),
    .rdata_o ()
  );

  // Insert accepts position up to length+1, delete up to length.
  assign pos_ext = CMP_W'(pos_q);
  assign limit   = (cmd_q == CMD_DELETE) ? CMP_W'(cnt_q) : CMP_W'(cnt_q) + CMP_W'(1);

  assign stat_o.is_delete = (cmd_q == CMD_DELETE);
  assign stat_o.pos_bad   = (pos_q == '0) || (pos_ext > limit);
  assign stat_o.nx_zero   = (nx == FREE_SLOT);
  assign stat_o.nx_head   = (nx == HEAD_SLOT);
  assign stat_o.walk_more = (n_q < pos_q);
  assign stat_o.init_last = (init_q == HEAD_SLOT);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      init_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.init_step) begin
        init_q <= SLOT_W'(init_q + 1'b1);
      end
      if (ctl_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (ctl_i.cnt_dec) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (ctl_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q <= in_cmd_i;
      pos_q <= in_position_i;
      val_q <= in_value_i;
    end
    if (ctl_i.j_ld) begin
      j_q <= nx;
    end
    if (ctl_i.walk_start) begin
      k_q <= HEAD_SLOT;
      n_q <= POS_W'(1);
    end else if (ctl_i.walk_step) begin
      k_q <= nx;
      n_q <= n_q + 1'b1;
    end
    if (ctl_i.status_ld) begin
      status_q <= ctl_i.status;
    end
    if (ctl_i.out_ld) begin
      out_status_q <= status_q;
      out_len_q    <= LEN_W'(cnt_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_length_o = out_len_q;

  `SLL_ASSERT(a_cnt_range, cnt_q <= SLOT_W'(CNT_MAX), "length counter above capacity")
  `SLL_ASSERT(a_cnt_step, (cnt_q != $past(cnt_q)) |-> $past(ctl_i.cnt_inc || ctl_i.cnt_dec),
              "length counter moved outside a completed operation")
  `SLL_ASSERT(a_j_slot,
              (ctl_i.link_we && ctl_i.waddr_sel == WA_J) |-> (j_q != FREE_SLOT && j_q != HEAD_SLOT),
              "splice slot is a chain head")
  `SLL_ASSERT(a_walk_bound, ctl_i.walk_step |-> (n_q < pos_q), "walk ran past the position")
  `SLL_ASSERT_ALWAYS(a_out_reset, !rst_ni |-> !out_valid_q, "result valid during reset")

endmodule

[design/static_linked_list_engine.sv]
// Cursor-array linked list: slot 0 heads the free chain, the last slot heads the data
// list, and an item either inserts a value before a 1-based position or deletes the
// element at a position, giving one result with a status and the list length. After
// reset the link memory is swept once to build the free chain, one slot a cycle, while
// in_i.ready stays low. For an accepted item, the walk to the predecessor follows one
// link per cycle through the link memory's registered read port, and the splice and
// free-chain updates add a few single writes on its one write port. The result waits
// in an output register, so the next item is accepted while it is still not taken.
module static_linked_list_engine (
  input logic      clk_i,
  input logic      rst_ni,
  sll_in_if.sink   in_i,
  sll_out_if.source out_o
);
  import sll_pkg::*;

  sll_ctl_t  ctl;
  sll_stat_t stat;

  // Sequence the walk, splice and free-chain steps.
  sll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  // Hold the item, the link and value memories, the length counter and the result.
  sll_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .in_cmd_i      (in_i.cmd),
    .in_position_i (in_i.position),
    .in_value_i    (in_i.value),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_status_o  (out_o.status),
    .out_length_o  (out_o.length)
  );

endmodule
